FILE: sv/aqdp_pkg.sv
// ----------------------------------------------------------------------------
// aqdp_pkg
// Shared types, codes and defaults of the admission queue with drop policy.
// ----------------------------------------------------------------------------
package aqdp_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TAG_BITS    = 16;
    localparam int DEF_TIME_BITS   = 32;

    localparam int CNT_BITS    = 7;
    localparam int POLICY_BITS = 2;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 3;
    localparam int SEED_BITS   = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [SEED_BITS-1:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [SEED_BITS-1:0] SEED_RESET = 32'd1;
    localparam logic [CNT_BITS-1:0]  CAP_RESET  = 7'd64;

    localparam logic [CMD_BITS-1:0] CMD_ARRIVE   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FINISH   = 2'd2;

    localparam logic [POLICY_BITS-1:0] POL_REFUSE   = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_DROP_NEW = 2'd1;
    localparam logic [POLICY_BITS-1:0] POL_HEAD     = 2'd2;
    localparam logic [POLICY_BITS-1:0] POL_RANDOM   = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_ACCEPTED    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_REFUSED     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NEW_DROPPED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_Q_DROPPED   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DISPATCHED  = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NONE_WAIT   = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_FINISHED    = 3'd6;
    localparam logic [STATUS_BITS-1:0] ST_FIN_IGNORED = 3'd7;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DROP,
        S_DISP,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic [POLICY_BITS-1:0] policy;
        logic [CNT_BITS-1:0]    capacity;
        logic                   seed_load;
        logic [SEED_BITS-1:0]   seed;
    } cfg_t;

    typedef struct packed {
        logic                   load;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } emit_t;

endpackage

FILE: sv/aqdp_in_if.sv
// ----------------------------------------------------------------------------
// aqdp_in_if
// Command channel: valid, ready and one job command.
// ----------------------------------------------------------------------------
interface aqdp_in_if #(
    parameter int TAG_BITS  = aqdp_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS = aqdp_pkg::DEF_TIME_BITS
);
    logic                           valid;
    logic                           ready;
    logic [aqdp_pkg::CMD_BITS-1:0]  cmd;
    logic [TAG_BITS-1:0]            conn_tag;
    logic [TIME_BITS-1:0]           time_now;

    modport source (output valid, cmd, conn_tag, time_now, input ready);
    modport sink   (input valid, cmd, conn_tag, time_now, output ready);
endinterface

FILE: sv/aqdp_out_if.sv
// ----------------------------------------------------------------------------
// aqdp_out_if
// Result channel: valid, ready and one event report.
// ----------------------------------------------------------------------------
interface aqdp_out_if #(
    parameter int TAG_BITS  = aqdp_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS = aqdp_pkg::DEF_TIME_BITS
);
    logic                              valid;
    logic                              ready;
    logic [aqdp_pkg::STATUS_BITS-1:0]  status;
    logic [TAG_BITS-1:0]               out_tag;
    logic [TIME_BITS-1:0]              arrival_stamp;
    logic [TIME_BITS-1:0]              wait_time;
    logic [aqdp_pkg::CNT_BITS-1:0]     waiting_now;
    logic [aqdp_pkg::CNT_BITS-1:0]     running_now;
    logic                              last;

    modport source (output valid, status, out_tag, arrival_stamp, wait_time,
                     waiting_now, running_now, last, input ready);
    modport sink   (input valid, status, out_tag, arrival_stamp, wait_time,
                     waiting_now, running_now, last, output ready);
endinterface

FILE: sv/aqdp_ram.sv
// ----------------------------------------------------------------------------
// aqdp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module aqdp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/aqdp_ctrl.sv
// ----------------------------------------------------------------------------
// aqdp_ctrl
// Command sequencer: ring pointers, counts, LFSR and the entry RAM.
// ----------------------------------------------------------------------------
module aqdp_ctrl #(
    parameter int QUEUE_DEPTH = aqdp_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = aqdp_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS   = aqdp_pkg::DEF_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  aqdp_pkg::cfg_t                cfg,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  logic [aqdp_pkg::CMD_BITS-1:0] job_cmd,
    input  logic [TAG_BITS-1:0]           job_tag,
    input  logic [TIME_BITS-1:0]          job_time,
    input  logic                          emit_free,
    output aqdp_pkg::emit_t               emit,
    output logic [TAG_BITS-1:0]           emit_tag,
    output logic [TIME_BITS-1:0]          emit_stamp,
    output logic [TIME_BITS-1:0]          emit_wait,
    output logic [aqdp_pkg::CNT_BITS-1:0] waiting_now,
    output logic [aqdp_pkg::CNT_BITS-1:0] running_now
);
    import aqdp_pkg::*;

    localparam int IDX_BITS   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_BITS = TAG_BITS + TIME_BITS;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);

    state_t                 state_reg, state_next;
    logic [IDX_BITS-1:0]    head_reg, head_next;
    logic [IDX_BITS-1:0]    tail_reg, tail_next;
    logic [CNT_BITS-1:0]    wcnt_reg, wcnt_next;
    logic [CNT_BITS-1:0]    rcnt_reg, rcnt_next;
    logic [SEED_BITS-1:0]   lfsr_reg, lfsr_next;
    logic [CNT_BITS-1:0]    left_reg, left_next;
    logic                   use_lfsr_reg, use_lfsr_next;
    logic                   accept_reg, accept_next;
    logic                   arrive_reg, arrive_next;
    logic [STATUS_BITS-1:0] fin_reg, fin_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;

    logic                   issue;
    logic                   pick_tail;
    logic                   step_lfsr;
    logic [IDX_BITS-1:0]    rd_idx;
    logic [IDX_BITS-1:0]    head_inc;
    logic [IDX_BITS-1:0]    tail_inc;
    logic [IDX_BITS-1:0]    tail_dec;
    logic                   ram_we;
    logic [ENTRY_BITS-1:0]  rdata;
    logic [TAG_BITS-1:0]    rd_tag;
    logic [TIME_BITS-1:0]   rd_stamp;

    logic [CNT_BITS-1:0]    cap_eff;
    logic [CNT_BITS:0]      occ;
    logic [CNT_BITS:0]      occ_mid;
    logic                   full;
    logic                   still_full;
    logic [CNT_BITS-1:0]    drops;
    logic [CNT_BITS-1:0]    w_mid;
    logic                   use_plan;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    assign rd_tag   = rdata[ENTRY_BITS-1:TIME_BITS];
    assign rd_stamp = rdata[TIME_BITS-1:0];

    // admission plan for an arrive command
    always_comb
    begin
        if (cfg.capacity == '0)
        begin
            cap_eff = CNT_BITS'(1);
        end
        else if (32'(cfg.capacity) > QUEUE_DEPTH)
        begin
            cap_eff = CNT_BITS'(QUEUE_DEPTH);
        end
        else
        begin
            cap_eff = cfg.capacity;
        end
        occ  = {1'b0, wcnt_reg} + {1'b0, rcnt_reg};
        full = occ >= {1'b0, cap_eff};
        case (cfg.policy)
            POL_HEAD:
            begin
                drops = (wcnt_reg != '0) ? CNT_BITS'(1) : '0;
            end
            POL_RANDOM:
            begin
                drops = (wcnt_reg == CNT_BITS'(1)) ? CNT_BITS'(1) : (wcnt_reg >> 1);
            end
            default:
            begin
                drops = '0;
            end
        endcase
        w_mid      = wcnt_reg - drops;
        occ_mid    = {1'b0, w_mid} + {1'b0, rcnt_reg};
        still_full = occ_mid >= {1'b0, cap_eff};
        use_plan   = (cfg.policy == POL_RANDOM) && (wcnt_reg > CNT_BITS'(1));
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        wcnt_next     = wcnt_reg;
        rcnt_next     = rcnt_reg;
        lfsr_next     = lfsr_reg;
        left_next     = left_reg;
        use_lfsr_next = use_lfsr_reg;
        accept_next   = accept_reg;
        arrive_next   = arrive_reg;
        fin_next      = fin_reg;
        tag_next      = tag_reg;
        now_next      = now_reg;
        job_ready     = 1'b0;
        issue         = 1'b0;
        pick_tail     = 1'b0;
        step_lfsr     = 1'b0;
        ram_we        = 1'b0;
        emit          = '0;
        emit_tag      = '0;
        emit_stamp    = '0;
        emit_wait     = '0;

        case (state_reg)
            S_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    tag_next    = job_tag;
                    now_next    = job_time;
                    accept_next = 1'b0;
                    arrive_next = 1'b0;
                    case (job_cmd)
                        CMD_ARRIVE:
                        begin
                            arrive_next = 1'b1;
                            state_next  = S_FINAL;
                            if (!full)
                            begin
                                accept_next = 1'b1;
                                fin_next    = ST_ACCEPTED;
                                wcnt_next   = wcnt_reg + 1'b1;
                            end
                            else if (cfg.policy == POL_REFUSE)
                            begin
                                fin_next = ST_REFUSED;
                            end
                            else if (cfg.policy == POL_DROP_NEW)
                            begin
                                fin_next = ST_NEW_DROPPED;
                            end
                            else
                            begin
                                accept_next = !still_full;
                                fin_next    = still_full ? ST_NEW_DROPPED : ST_ACCEPTED;
                                wcnt_next   = w_mid + CNT_BITS'(!still_full);
                                if (drops != '0)
                                begin
                                    issue         = 1'b1;
                                    step_lfsr     = use_plan;
                                    pick_tail     = use_plan & lfsr_reg[0];
                                    use_lfsr_next = use_plan;
                                    left_next     = drops - 1'b1;
                                    state_next    = S_DROP;
                                end
                            end
                        end
                        CMD_DISPATCH:
                        begin
                            if (wcnt_reg == '0)
                            begin
                                fin_next   = ST_NONE_WAIT;
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                issue      = 1'b1;
                                wcnt_next  = wcnt_reg - 1'b1;
                                rcnt_next  = rcnt_reg + 1'b1;
                                state_next = S_DISP;
                            end
                        end
                        CMD_FINISH:
                        begin
                            state_next = S_FINAL;
                            if (rcnt_reg == '0)
                            begin
                                fin_next = ST_FIN_IGNORED;
                            end
                            else
                            begin
                                fin_next  = ST_FINISHED;
                                rcnt_next = rcnt_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DROP:
            begin
                if (emit_free)
                begin
                    emit.load   = 1'b1;
                    emit.status = ST_Q_DROPPED;
                    emit_tag    = rd_tag;
                    emit_stamp  = rd_stamp;
                    if (left_reg != '0)
                    begin
                        issue     = 1'b1;
                        step_lfsr = use_lfsr_reg;
                        pick_tail = use_lfsr_reg & lfsr_reg[0];
                        left_next = left_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINAL;
                    end
                end
            end
            S_DISP:
            begin
                if (emit_free)
                begin
                    emit.load   = 1'b1;
                    emit.status = ST_DISPATCHED;
                    emit.last   = 1'b1;
                    emit_tag    = rd_tag;
                    emit_stamp  = rd_stamp;
                    emit_wait   = now_reg - rd_stamp;
                    state_next  = S_IDLE;
                end
            end
            S_FINAL:
            begin
                if (emit_free)
                begin
                    emit.load   = 1'b1;
                    emit.status = fin_reg;
                    emit.last   = 1'b1;
                    emit_tag    = arrive_reg ? tag_reg : '0;
                    emit_stamp  = arrive_reg ? now_reg : '0;
                    if (accept_reg)
                    begin
                        ram_we    = 1'b1;
                        tail_next = tail_inc;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // read issue: one end of the ring per transfer
        if (issue && pick_tail)
        begin
            rd_idx    = tail_dec;
            tail_next = tail_dec;
        end
        else
        begin
            rd_idx = head_reg;
            if (issue)
            begin
                head_next = head_inc;
            end
        end
        if (step_lfsr)
        begin
            lfsr_next = {1'b0, lfsr_reg[SEED_BITS-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        end
        if (cfg.seed_load)
        begin
            lfsr_next = cfg.seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            wcnt_reg     <= '0;
            rcnt_reg     <= '0;
            lfsr_reg     <= SEED_RESET;
            left_reg     <= '0;
            use_lfsr_reg <= 1'b0;
            accept_reg   <= 1'b0;
            arrive_reg   <= 1'b0;
            fin_reg      <= ST_ACCEPTED;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            wcnt_reg     <= wcnt_next;
            rcnt_reg     <= rcnt_next;
            lfsr_reg     <= lfsr_next;
            left_reg     <= left_next;
            use_lfsr_reg <= use_lfsr_next;
            accept_reg   <= accept_next;
            arrive_reg   <= arrive_next;
            fin_reg      <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        now_reg <= now_next;
    end

    assign waiting_now = wcnt_reg;
    assign running_now = rcnt_reg;

    aqdp_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({tag_reg, now_reg}),
        .re    (issue),
        .raddr (rd_idx),
        .rdata (rdata)
    );

endmodule

FILE: sv/admission_queue_drop_policy.sv
// ----------------------------------------------------------------------------
// admission_queue_drop_policy
// Ring-buffer job admission queue with refuse, drop-new, drop-head and
// random-drop overflow handling.
// ----------------------------------------------------------------------------
// One command is taken at a time. Arrive, finish and empty dispatch go from
// idle to the final state; a dispatch goes to the dispatch state, as the entry
// RAM read is registered. Each overflow drop passes the drop state with one RAM
// read; random drop sheds half the waiting entries, or the only one. A result
// register sits on the output; results stall the sequencer only while it is
// held. Every result of a command carries the waiting and running counts as
// they stand after the whole command. Configuration is written through cfg_we,
// cfg_index and cfg_data; a seed write reloads the LFSR at once.
// ----------------------------------------------------------------------------
module admission_queue_drop_policy #(
    parameter int QUEUE_DEPTH = aqdp_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS    = aqdp_pkg::DEF_TAG_BITS,
    parameter int TIME_BITS   = aqdp_pkg::DEF_TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    aqdp_in_if.sink                            jobs,
    aqdp_out_if.source                         results,
    input  logic                               cfg_we,
    input  logic [aqdp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [aqdp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import aqdp_pkg::*;

    logic [POLICY_BITS-1:0] policy_reg;
    logic [CNT_BITS-1:0]    capacity_reg;
    cfg_t                   cfg;
    emit_t                  emit;
    logic                   emit_free;
    logic [TAG_BITS-1:0]    emit_tag;
    logic [TIME_BITS-1:0]   emit_stamp;
    logic [TIME_BITS-1:0]   emit_wait;
    logic [CNT_BITS-1:0]    waiting_now;
    logic [CNT_BITS-1:0]    running_now;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    logic [TIME_BITS-1:0]   stamp_reg;
    logic [TIME_BITS-1:0]   wait_reg;
    logic [CNT_BITS-1:0]    wnow_reg;
    logic [CNT_BITS-1:0]    rnow_reg;
    logic                   last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg   <= POL_REFUSE;
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY:
                begin
                    policy_reg <= cfg_data[POLICY_BITS-1:0];
                end
                CFG_CAPACITY:
                begin
                    capacity_reg <= cfg_data[CNT_BITS-1:0];
                end
                default:
                begin
                    policy_reg <= policy_reg;
                end
            endcase
        end
    end

    assign cfg.policy    = policy_reg;
    assign cfg.capacity  = capacity_reg;
    assign cfg.seed_load = cfg_we && (cfg_index == CFG_SEED);
    assign cfg.seed      = cfg_data[SEED_BITS-1:0];

    assign emit_free = !out_valid_reg || results.ready;

    aqdp_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .job_valid   (jobs.valid),
        .job_ready   (jobs.ready),
        .job_cmd     (jobs.cmd),
        .job_tag     (jobs.conn_tag),
        .job_time    (jobs.time_now),
        .emit_free   (emit_free),
        .emit        (emit),
        .emit_tag    (emit_tag),
        .emit_stamp  (emit_stamp),
        .emit_wait   (emit_wait),
        .waiting_now (waiting_now),
        .running_now (running_now)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            status_reg <= emit.status;
            tag_reg    <= emit_tag;
            stamp_reg  <= emit_stamp;
            wait_reg   <= emit_wait;
            wnow_reg   <= waiting_now;
            rnow_reg   <= running_now;
            last_reg   <= emit.last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.status        = status_reg;
    assign results.out_tag       = tag_reg;
    assign results.arrival_stamp = stamp_reg;
    assign results.wait_time     = wait_reg;
    assign results.waiting_now   = wnow_reg;
    assign results.running_now   = rnow_reg;
    assign results.last          = last_reg;

endmodule

FILE: bench/admission_queue_drop_policy_test.sv
// ----------------------------------------------------------------------------
// admission_queue_drop_policy_test
// Self-checking bench for the admission queue with drop policy. Directed
// tasks walk through empty-queue commands, refusal, drop-new, drop-head,
// over-capacity and random-drop corner cases; random phases then run mixed
// job traffic under many policy, capacity and seed settings. A command model
// of the queue predicts every report; a checker compares each result
// transfer against the oldest prediction while both channels idle at random.
// ----------------------------------------------------------------------------
module admission_queue_drop_policy_test;
    import aqdp_pkg::*;

    localparam int TAG_W         = DEF_TAG_BITS;
    localparam int TIME_W        = DEF_TIME_BITS;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CMD_BITS-1:0] CMD_IGNORED = 2'd3;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_W-1:0]       tag;
        logic [TIME_W-1:0]      stamp;
        logic [TIME_W-1:0]      wait_us;
        logic [CNT_BITS-1:0]    waiting;
        logic [CNT_BITS-1:0]    running;
        logic                   last;
    } report_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    aqdp_in_if  #(.TAG_BITS(TAG_W), .TIME_BITS(TIME_W)) jobs_if ();
    aqdp_out_if #(.TAG_BITS(TAG_W), .TIME_BITS(TIME_W)) results_if ();

    admission_queue_drop_policy #(
        .QUEUE_DEPTH(DEF_QUEUE_DEPTH),
        .TAG_BITS   (TAG_W),
        .TIME_BITS  (TIME_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .jobs     (jobs_if),
        .results  (results_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // queue model
    logic [TAG_W-1:0]       ring_tag   [DEF_QUEUE_DEPTH];
    logic [TIME_W-1:0]      ring_stamp [DEF_QUEUE_DEPTH];
    logic [5:0]             q_head;
    logic [5:0]             q_tail;
    logic [CNT_BITS-1:0]    n_waiting;
    logic [CNT_BITS-1:0]    n_running;
    logic [SEED_BITS-1:0]   lfsr_state;
    logic [POLICY_BITS-1:0] cur_policy;
    logic [CNT_BITS-1:0]    cur_capacity;

    report_t step_reports[$];
    report_t expected_reports[$];

    int          faults;
    int          send_quiet;
    logic [31:0] clock_us;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic queue_full();
        logic [7:0] cap;
        if (cur_capacity == 7'd0)
            cap = 8'd1;
        else if (cur_capacity > 7'd64)
            cap = 8'd64;
        else
            cap = {1'b0, cur_capacity};
        return ({1'b0, n_waiting} + {1'b0, n_running}) >= cap;
    endfunction

    function automatic void note_event(logic [STATUS_BITS-1:0] st, logic [TAG_W-1:0] tg,
                                       logic [TIME_W-1:0] sp, logic [TIME_W-1:0] wt);
        report_t r;
        r = '0;
        r.status  = st;
        r.tag     = tg;
        r.stamp   = sp;
        r.wait_us = wt;
        step_reports.push_back(r);
    endfunction

    function automatic void shed_one(logic from_tail);
        logic [5:0] slot;
        if (n_waiting == 7'd0)
            return;
        if (from_tail)
        begin
            q_tail = q_tail - 6'd1;
            slot   = q_tail;
        end
        else
        begin
            slot   = q_head;
            q_head = q_head + 6'd1;
        end
        n_waiting = n_waiting - 7'd1;
        note_event(ST_Q_DROPPED, ring_tag[slot], ring_stamp[slot], '0);
    endfunction

    function automatic void predict_job(logic [CMD_BITS-1:0] op, logic [TAG_W-1:0] tag,
                                        logic [TIME_W-1:0] now);
        logic       take;
        logic       bit_out;
        logic [5:0] slot;
        report_t    r;
        step_reports.delete();
        case (op)
            CMD_ARRIVE:
            begin
                take = 1'b1;
                if (queue_full())
                begin
                    if (cur_policy == POL_REFUSE)
                    begin
                        note_event(ST_REFUSED, tag, now, '0);
                        take = 1'b0;
                    end
                    else if (cur_policy == POL_DROP_NEW)
                        take = 1'b0;
                    else if (cur_policy == POL_HEAD || n_waiting == 7'd1)
                        shed_one(1'b0);
                    else if (n_waiting > 7'd1)
                    begin
                        repeat (n_waiting >> 1)
                        begin
                            bit_out    = lfsr_state[0];
                            lfsr_state = lfsr_state >> 1;
                            if (bit_out)
                                lfsr_state = lfsr_state ^ LFSR_TAPS;
                            shed_one(bit_out);
                        end
                    end
                    if (cur_policy != POL_REFUSE && (!take || queue_full()))
                    begin
                        note_event(ST_NEW_DROPPED, tag, now, '0);
                        take = 1'b0;
                    end
                end
                if (take)
                begin
                    ring_tag[q_tail]   = tag;
                    ring_stamp[q_tail] = now;
                    q_tail    = q_tail + 6'd1;
                    n_waiting = n_waiting + 7'd1;
                    note_event(ST_ACCEPTED, tag, now, '0);
                end
            end
            CMD_DISPATCH:
            begin
                if (n_waiting == 7'd0)
                    note_event(ST_NONE_WAIT, '0, '0, '0);
                else
                begin
                    slot      = q_head;
                    q_head    = q_head + 6'd1;
                    n_waiting = n_waiting - 7'd1;
                    n_running = n_running + 7'd1;
                    note_event(ST_DISPATCHED, ring_tag[slot], ring_stamp[slot],
                               now - ring_stamp[slot]);
                end
            end
            CMD_FINISH:
            begin
                if (n_running == 7'd0)
                    note_event(ST_FIN_IGNORED, '0, '0, '0);
                else
                begin
                    n_running = n_running - 7'd1;
                    note_event(ST_FINISHED, '0, '0, '0);
                end
            end
            default:
            begin
            end
        endcase
        foreach (step_reports[k])
        begin
            r         = step_reports[k];
            r.waiting = n_waiting;
            r.running = n_running;
            r.last    = (k == step_reports.size() - 1);
            expected_reports.push_back(r);
        end
    endfunction

    // result checker and receiver stalls
    initial
    begin : result_check
        report_t got;
        report_t want;
        int      hold;
        int      quiet;
        hold  = 0;
        quiet = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && results_if.valid && results_if.ready)
            begin
                got.status  = results_if.status;
                got.tag     = results_if.out_tag;
                got.stamp   = results_if.arrival_stamp;
                got.wait_us = results_if.wait_time;
                got.waiting = results_if.waiting_now;
                got.running = results_if.running_now;
                got.last    = results_if.last;
                if (expected_reports.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("unexpected transfer: status %0d tag %h", got.status, got.tag);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status || got.tag !== want.tag
                        || got.stamp !== want.stamp || got.wait_us !== want.wait_us
                        || got.waiting !== want.waiting || got.running !== want.running
                        || got.last !== want.last)
                    begin
                        faults++;
                        if (faults <= 10)
                        begin
                            $display("mismatch exp: st %0d tag %h stamp %h wait %h w %0d r %0d last %b",
                                     want.status, want.tag, want.stamp, want.wait_us,
                                     want.waiting, want.running, want.last);
                            $display("         got: st %0d tag %h stamp %h wait %h w %0d r %0d last %b",
                                     got.status, got.tag, got.stamp, got.wait_us,
                                     got.waiting, got.running, got.last);
                        end
                    end
                end
                if (quiet > 0)
                begin
                    hold = 0;
                    quiet--;
                end
                else
                begin
                    hold = $urandom_range(0, 3);
                    if ($urandom_range(0, 24) == 0)
                        quiet = $urandom_range(8, 30);
                end
            end
            @(negedge clk);
            if (hold > 0)
            begin
                results_if.ready <= 1'b0;
                hold--;
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    task automatic send_job(input logic [CMD_BITS-1:0] op, input logic [TAG_W-1:0] tag,
                            input logic [TIME_W-1:0] now);
        int gap;
        if (send_quiet > 0)
        begin
            gap = 0;
            send_quiet--;
        end
        else
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 24) == 0)
                send_quiet = $urandom_range(8, 30);
        end
        repeat (gap)
        begin
            jobs_if.valid <= 1'b0;
            @(negedge clk);
        end
        jobs_if.valid    <= 1'b1;
        jobs_if.cmd      <= op;
        jobs_if.conn_tag <= tag;
        jobs_if.time_now <= now;
        do
            @(posedge clk);
        while (!jobs_if.ready);
        predict_job(op, tag, now);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        jobs_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_reports.size() > 0);
    endtask

    // registers change only with the queue idle
    task automatic set_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_POLICY:   cur_policy   = value[POLICY_BITS-1:0];
            CFG_CAPACITY: cur_capacity = value[CNT_BITS-1:0];
            CFG_SEED:     lfsr_state   = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_idle_commands();
        send_job(CMD_DISPATCH, 16'hFFFF, 32'hFFFF_FFFF);
        send_job(CMD_FINISH, 16'hFFFF, 32'hFFFF_FFFF);
        send_job(CMD_IGNORED, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_refuse_when_full();
        set_register(CFG_POLICY, 32'(POL_REFUSE));
        set_register(CFG_CAPACITY, 32'd2);
        send_job(CMD_ARRIVE, 16'h0000, 32'h0000_0000);
        send_job(CMD_ARRIVE, 16'hFFFF, 32'hFFFF_FFFF);
        send_job(CMD_ARRIVE, 16'h1234, 32'd10);
        send_job(CMD_DISPATCH, 16'h0000, 32'd5);
        // wait time wraps around
        send_job(CMD_DISPATCH, 16'h0000, 32'd3);
    endtask

    task automatic test_drop_head();
        set_register(CFG_POLICY, 32'(POL_HEAD));
        // full of running jobs, nothing to drop
        send_job(CMD_ARRIVE, 16'hA5A5, 32'd20);
        send_job(CMD_FINISH, 16'h0000, 32'd25);
        send_job(CMD_ARRIVE, 16'h5A5A, 32'd30);
        send_job(CMD_ARRIVE, 16'hC3C3, 32'd40);
    endtask

    task automatic test_drop_new_and_over_capacity();
        set_register(CFG_POLICY, 32'(POL_DROP_NEW));
        send_job(CMD_ARRIVE, 16'h0F0F, 32'd50);
        set_register(CFG_CAPACITY, 32'd0);
        set_register(CFG_POLICY, 32'(POL_HEAD));
        send_job(CMD_ARRIVE, 16'hF0F0, 32'd60);
    endtask

    task automatic test_random_drop_edges();
        set_register(CFG_POLICY, 32'(POL_RANDOM));
        send_job(CMD_ARRIVE, 16'h1111, 32'd70);
        send_job(CMD_FINISH, 16'h0000, 32'd75);
        set_register(CFG_CAPACITY, 32'd1);
        send_job(CMD_ARRIVE, 16'h2222, 32'd80);
        send_job(CMD_ARRIVE, 16'h3333, 32'd90);
        // zero seed keeps every drop at the head
        set_register(CFG_SEED, 32'd0);
        set_register(CFG_CAPACITY, 32'd4);
        send_job(CMD_ARRIVE, 16'h4444, 32'd100);
        send_job(CMD_ARRIVE, 16'h5555, 32'd110);
        send_job(CMD_ARRIVE, 16'h6666, 32'd120);
        send_job(CMD_ARRIVE, 16'h7777, 32'd130);
        send_job(CMD_DISPATCH, 16'h0000, 32'd200);
        send_job(CMD_FINISH, 16'h0000, 32'd210);
    endtask

    task automatic run_phase(input logic [POLICY_BITS-1:0] pol, input logic [CNT_BITS-1:0] cap,
                             input logic [SEED_BITS-1:0] seed, input int items,
                             input int arrive_pct);
        logic [CMD_BITS-1:0] op;
        int                  pick;
        set_register(CFG_POLICY, 32'(pol));
        set_register(CFG_CAPACITY, 32'(cap));
        set_register(CFG_SEED, seed);
        repeat (items)
        begin
            if ($urandom_range(0, 99) < arrive_pct)
                op = CMD_ARRIVE;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    op = CMD_DISPATCH;
                else if (pick < 9)
                    op = CMD_FINISH;
                else
                    op = CMD_IGNORED;
            end
            if ($urandom_range(0, 19) == 0)
                clock_us = $urandom;
            else
                clock_us = clock_us + $urandom_range(0, 5000);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            send_job(op, 16'($urandom), clock_us);
        end
    endtask

    task automatic test_random_traffic();
        clock_us = $urandom;
        // deep queue so random drop sheds up to half of it
        run_phase(POL_RANDOM, 7'd127, 32'hFFFF_FFFF, 90, 85);
        run_phase(POL_REFUSE, 7'd3, $urandom, 50, 60);
        run_phase(POL_DROP_NEW, 7'd64, $urandom, 50, 70);
        run_phase(POL_HEAD, 7'($urandom_range(1, 8)), $urandom, 50, 65);
        run_phase(POL_RANDOM, 7'($urandom_range(2, 16)), $urandom, 60, 70);
        repeat (4)
            run_phase(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom, 30,
                      $urandom_range(40, 80));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        jobs_if.valid    = 1'b0;
        jobs_if.cmd      = CMD_ARRIVE;
        jobs_if.conn_tag = '0;
        jobs_if.time_now = '0;
        faults           = 0;
        send_quiet       = 0;
        clock_us         = '0;
        q_head           = '0;
        q_tail           = '0;
        n_waiting        = '0;
        n_running        = '0;
        lfsr_state       = SEED_RESET;
        cur_policy       = POL_REFUSE;
        cur_capacity     = CAP_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_commands();
        test_refuse_when_full();
        test_drop_head();
        test_drop_new_and_over_capacity();
        test_random_drop_edges();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
